@@ rtl/shnt_pkg.sv @@
// Package for the sorted held note table: sizes, function and status codes,
// and the note and command types shared by the table, its sequencer and the checker.
// No dependencies.
package shnt_pkg;

    localparam int MAX_NOTES = 16;
    localparam int LEN_W     = $clog2(MAX_NOTES + 1);
    localparam int IDX_W     = $clog2(MAX_NOTES);
    localparam int POS_W     = 4;
    localparam int CMP_W     = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int TONE_W    = 7;
    localparam int CHAN_W    = 4;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM_CHN = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [CHAN_W-1:0] chan;
    } note_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  keep;
        logic  clear;
        note_t data;
    } q_cmd_t;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] status;
        note_t             query;
    } seq_res_t;

endpackage

@@ rtl/shnt_queue.sv @@
// Recirculating note queue: the head entry is read at a fixed place, entries
// shift down on a pop and are appended at the tail. Uses shnt_pkg.
module shnt_queue
    import shnt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_cmd_t           cmd,
    output note_t            head,
    output note_t            tail,
    output logic [LEN_W-1:0] len
);

    note_t            ent_reg [MAX_NOTES];
    note_t            tail_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_m1;

    assign len_m1 = len_reg - LEN_W'(1);

    always_comb
    begin
        len_next = len_reg;
        if (cmd.clear)
        begin
            len_next = '0;
        end
        else if (cmd.push)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (cmd.pop && !cmd.keep)
        begin
            len_next = len_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            for (int k = 0; k < MAX_NOTES - 1; k++)
            begin
                ent_reg[k] <= (cmd.keep && (len_m1 == LEN_W'(k))) ? ent_reg[0] : ent_reg[k + 1];
            end
            if (cmd.keep && (len_m1 == LEN_W'(MAX_NOTES - 1)))
            begin
                ent_reg[MAX_NOTES - 1] <= ent_reg[0];
            end
            if (cmd.keep)
            begin
                tail_reg <= ent_reg[0];
            end
        end
        else if (cmd.push)
        begin
            ent_reg[len_reg[IDX_W-1:0]] <= cmd.data;
            tail_reg                    <= cmd.data;
        end
    end

    assign head = ent_reg[0];
    assign tail = tail_reg;
    assign len  = len_reg;

endmodule

@@ rtl/shnt_seq.sv @@
// Sequencer for the note table: takes one item, walks the queue one entry per
// cycle, pausing where an add inserts its note, through a single tone and channel comparator. Uses shnt_pkg.
module shnt_seq
    import shnt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [TONE_W-1:0]  tone,
    input  logic [CHAN_W-1:0]  chan,
    input  logic [POS_W-1:0]   position,
    input  logic               from_top,
    input  logic               slot_free,
    input  note_t              head,
    input  logic [LEN_W-1:0]   len,
    output q_cmd_t             cmd,
    output seq_res_t           res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg;
    note_t             note_reg;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  step_reg, step_next;
    logic [LEN_W-1:0]  idx_reg;
    logic              ins_reg, ins_next;
    logic              found_reg, found_next;
    logic [STAT_W-1:0] status_reg, status_next;
    note_t             query_reg, query_next;

    logic              accept;
    logic              pos_bad;
    logic [LEN_W-1:0]  idx_calc;
    logic              is_match;
    logic              chan_hit;
    logic              drop;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pos_bad  = CMP_W'(position) >= CMP_W'(len);
    assign idx_calc = from_top ? (len - LEN_W'(1) - LEN_W'(position)) : LEN_W'(position);
    assign chan_hit = (head.chan == note_reg.chan);
    assign is_match = (head.tone == note_reg.tone) && chan_hit;
    assign drop     = ((func_reg == FUNC_REMOVE) && !found_reg && is_match)
                   || ((func_reg == FUNC_REM_CHN) && chan_hit);

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        ins_next    = ins_reg;
        found_next  = found_reg;
        status_next = status_reg;
        query_next  = query_reg;
        cmd         = '0;
        cmd.data    = note_reg;
        res         = '0;
        res.status  = status_reg;
        res.query   = query_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rem_next    = len;
                    step_next   = '0;
                    ins_next    = 1'b0;
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    query_next  = '0;
                    state_next  = S_FIN;
                    case (func)
                        FUNC_ADD:
                        begin
                            if (len >= LEN_W'(MAX_NOTES))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            status_next = STAT_NOT_FOUND;
                            state_next  = S_WALK;
                        end
                        FUNC_REM_CHN:
                        begin
                            state_next = S_WALK;
                        end
                        FUNC_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        FUNC_QUERY:
                        begin
                            if (pos_bad)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    if ((func_reg == FUNC_ADD) && !ins_reg)
                    begin
                        cmd.push = 1'b1;
                        ins_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else if ((func_reg == FUNC_ADD) && !ins_reg && (head.tone >= note_reg.tone))
                begin
                    cmd.push = 1'b1;
                    ins_next = 1'b1;
                end
                else
                begin
                    cmd.pop   = 1'b1;
                    cmd.keep  = !drop;
                    rem_next  = rem_reg - LEN_W'(1);
                    step_next = step_reg + LEN_W'(1);
                    if ((func_reg == FUNC_REMOVE) && drop)
                    begin
                        found_next  = 1'b1;
                        status_next = STAT_OK;
                    end
                    if ((func_reg == FUNC_QUERY) && (step_reg == idx_reg))
                    begin
                        query_next = head;
                    end
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    res.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func;
            note_reg.tone <= tone;
            note_reg.chan <= chan;
            idx_reg       <= idx_calc;
        end
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        ins_reg    <= ins_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        query_reg  <= query_next;
    end

endmodule

@@ rtl/sorted_held_note_table.sv @@
// Sorted held note table top level: sequencer, recirculating queue, output register.
// Add, remove, remove-channel and in-range query walk all held notes, one entry per
// cycle through the shared comparator, pausing where an add inserts its note.
// Clear, full add, out-of-range query and unused codes skip the walk and go straight to the result.
// A new item is taken once the result is registered, so only one item is in flight at a time.
// Reset clears the count and control state; stored entries stay undefined until written.
module sorted_held_note_table
    import shnt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [TONE_W-1:0] tone,
    input  logic [CHAN_W-1:0] chan,
    input  logic [POS_W-1:0]  position,
    input  logic              from_top,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [4:0]        count,
    output logic [TONE_W-1:0] query_tone,
    output logic [CHAN_W-1:0] query_chan,
    output logic [TONE_W-1:0] top_tone,
    output logic [CHAN_W-1:0] top_chan,
    output logic [TONE_W-1:0] bottom_tone,
    output logic [CHAN_W-1:0] bottom_chan,
    output logic              is_empty
);

    q_cmd_t           cmd;
    seq_res_t         res;
    note_t            head;
    note_t            tail;
    logic [LEN_W-1:0] len;
    logic             slot_free;
    logic             out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [LEN_W-1:0] count_reg;
    note_t            query_reg;
    note_t            top_reg;
    note_t            bottom_reg;
    logic             empty_reg;

    assign slot_free = !out_valid_reg || out_ready;

    shnt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .tone      (tone),
        .chan      (chan),
        .position  (position),
        .from_top  (from_top),
        .slot_free (slot_free),
        .head      (head),
        .len       (len),
        .cmd       (cmd),
        .res       (res)
    );

    shnt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .tail  (tail),
        .len   (len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            status_reg <= res.status;
            count_reg  <= len;
            query_reg  <= res.query;
            empty_reg  <= (len == '0);
            top_reg    <= (len == '0) ? '0 : tail;
            bottom_reg <= (len == '0) ? '0 : head;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign count       = 5'(count_reg);
    assign query_tone  = query_reg.tone;
    assign query_chan  = query_reg.chan;
    assign top_tone    = top_reg.tone;
    assign top_chan    = top_reg.chan;
    assign bottom_tone = bottom_reg.tone;
    assign bottom_chan = bottom_reg.chan;
    assign is_empty    = empty_reg;

endmodule

@@ rtl/shnt_checker.sv @@
// Port-level checker for the sorted held note table, bound to the top level.
// Uses shnt_pkg for sizes and status codes.
module shnt_checker
    import shnt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic [STAT_W-1:0] status,
    input logic [4:0]        count,
    input logic [TONE_W-1:0] query_tone,
    input logic [TONE_W-1:0] top_tone,
    input logic [TONE_W-1:0] bottom_tone,
    input logic              is_empty
);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= 5'(MAX_NOTES)))
        else $error("count above table size");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_FULL)) |-> (count == 5'(MAX_NOTES)))
        else $error("full status with room left");

    a_sorted_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_empty) |-> (bottom_tone <= top_tone))
        else $error("lowest note above highest note");

    a_range_query: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_RANGE)) |-> (query_tone == '0))
        else $error("out of range query returned a tone");

endmodule

bind sorted_held_note_table shnt_checker u_shnt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .status      (status),
    .count       (count),
    .query_tone  (query_tone),
    .top_tone    (top_tone),
    .bottom_tone (bottom_tone),
    .is_empty    (is_empty)
);

@@ dv/tb.sv @@
// Testbench for sorted_held_note_table: directed and random note commands over valid/ready,
// with every reply checked field by field against a tracker of the sorted note table.
// Depends on shnt_pkg and the sorted_held_note_table RTL.
`timescale 1ns / 100ps

module tb;
    import shnt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;
    localparam int RANDOM_ITEMS = 1500;
    localparam int WIND_DOWN_ITEMS = 300;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [4:0]        count;
        note_t             query;
        note_t             top;
        note_t             bottom;
        logic              is_empty;
    } reply_t;

    class note_table_tracker;
        note_t       held[MAX_NOTES];
        int unsigned held_count;
        reply_t      replies_due[$];
        int unsigned mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        function void drop_entry(int unsigned at);
            int unsigned k;
            for (k = at; k + 1 < held_count; k++)
                held[k] = held[k + 1];
            held_count--;
        endfunction

        function void take_command(logic [FUNC_W-1:0] f, note_t n,
                                   logic [POS_W-1:0] pos, logic from_top);
            reply_t      r;
            int unsigned at;
            int unsigned k;
            r = '0;
            r.status = STAT_OK;
            case (f)
                FUNC_ADD:
                begin
                    if (held_count >= MAX_NOTES)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        at = 0;
                        while (at < held_count && held[at].tone < n.tone)
                            at++;
                        for (k = held_count; k > at; k--)
                            held[k] = held[k - 1];
                        held[at] = n;
                        held_count++;
                    end
                end
                FUNC_REMOVE:
                begin
                    r.status = STAT_NOT_FOUND;
                    for (k = 0; k < held_count; k++)
                    begin
                        if (held[k] == n)
                        begin
                            drop_entry(k);
                            r.status = STAT_OK;
                            break;
                        end
                    end
                end
                FUNC_REM_CHN:
                begin
                    k = 0;
                    while (k < held_count)
                    begin
                        if (held[k].chan == n.chan)
                            drop_entry(k);
                        else
                            k++;
                    end
                end
                FUNC_CLEAR:
                    held_count = 0;
                FUNC_QUERY:
                begin
                    if (pos >= held_count)
                        r.status = STAT_RANGE;
                    else if (from_top)
                        r.query = held[held_count - 1 - pos];
                    else
                        r.query = held[pos];
                end
                default:
                    ;
            endcase
            r.count = 5'(held_count);
            if (held_count == 0)
            begin
                r.is_empty = 1'b1;
            end
            else
            begin
                r.top    = held[held_count - 1];
                r.bottom = held[0];
            end
            replies_due.push_back(r);
        endfunction

        function string reply_text(reply_t r);
            return $sformatf("status %0d count %0d query %0d/%0d top %0d/%0d bottom %0d/%0d empty %0b",
                             r.status, r.count, r.query.tone, r.query.chan, r.top.tone,
                             r.top.chan, r.bottom.tone, r.bottom.chan, r.is_empty);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected reply: %s", $time, reply_text(got));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.count !== want.count
                || got.query.tone !== want.query.tone || got.query.chan !== want.query.chan
                || got.top.tone !== want.top.tone || got.top.chan !== want.top.chan
                || got.bottom.tone !== want.bottom.tone || got.bottom.chan !== want.bottom.chan
                || got.is_empty !== want.is_empty)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: reply mismatch", $time);
                    $display("    expected %s", reply_text(want));
                    $display("    actual   %s", reply_text(got));
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [FUNC_W-1:0] func = FUNC_CLEAR;
    logic [TONE_W-1:0] tone = '0;
    logic [CHAN_W-1:0] chan = '0;
    logic [POS_W-1:0]  position = '0;
    logic              from_top = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [STAT_W-1:0] status;
    logic [4:0]        count;
    logic [TONE_W-1:0] query_tone;
    logic [CHAN_W-1:0] query_chan;
    logic [TONE_W-1:0] top_tone;
    logic [CHAN_W-1:0] top_chan;
    logic [TONE_W-1:0] bottom_tone;
    logic [CHAN_W-1:0] bottom_chan;
    logic              is_empty;

    note_table_tracker tracker = new();
    bit                calm = 1'b0;
    bit                wind_down = 1'b0;
    int unsigned       fill_goal = MAX_NOTES;

    sorted_held_note_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .tone        (tone),
        .chan        (chan),
        .position    (position),
        .from_top    (from_top),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .count       (count),
        .query_tone  (query_tone),
        .query_chan  (query_chan),
        .top_tone    (top_tone),
        .top_chan    (top_chan),
        .bottom_tone (bottom_tone),
        .bottom_chan (bottom_chan),
        .is_empty    (is_empty)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_command(logic [FUNC_W-1:0] f, logic [TONE_W-1:0] t,
                                logic [CHAN_W-1:0] c, logic [POS_W-1:0] pos, logic top);
        note_t n;
        n.tone = t;
        n.chan = c;
        if (!calm && !wind_down && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        tone     <= t;
        chan     <= c;
        position <= pos;
        from_top <= top;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.take_command(f, n, pos, top);
    endtask

    task automatic pick_command(output logic [FUNC_W-1:0] f, output note_t n,
                                output logic [POS_W-1:0] pos, output logic top);
        int unsigned roll;
        int unsigned held;
        held = tracker.held_count;
        roll = $urandom_range(0, 99);
        n.tone = $urandom_range(0, 1) ? TONE_W'($urandom_range(58, 66)) : TONE_W'($urandom);
        n.chan = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 3)) : CHAN_W'($urandom);
        pos = POS_W'($urandom);
        top = 1'($urandom);
        if (roll < 3)
        begin
            f = FUNC_W'($urandom_range(FUNC_QUERY + 1, (1 << FUNC_W) - 1));
        end
        else if (roll < 5)
        begin
            f = FUNC_CLEAR;
        end
        else if (roll < 8)
        begin
            f = FUNC_REM_CHN;
            if (held > 0 && $urandom_range(0, 3) != 0)
                n.chan = tracker.held[$urandom_range(0, held - 1)].chan;
        end
        else if (roll < 30)
        begin
            f = FUNC_QUERY;
            if (held > 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(0, held - 1));
        end
        else if ((held < fill_goal) == (roll < 80))
        begin
            f = FUNC_ADD;
        end
        else
        begin
            f = FUNC_REMOVE;
            if (held > 0 && $urandom_range(0, 3) != 0)
                n = tracker.held[$urandom_range(0, held - 1)];
        end
    endtask

    initial
    begin
        reply_t      got;
        int unsigned stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                got.status   = status;
                got.count    = count;
                got.query    = {query_tone, query_chan};
                got.top      = {top_tone, top_chan};
                got.bottom   = {bottom_tone, bottom_chan};
                got.is_empty = is_empty;
                tracker.check_reply(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && !wind_down && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [FUNC_W-1:0] f;
        note_t             n;
        logic [POS_W-1:0]  pos;
        logic              top;
        int unsigned       done_items;
        int unsigned       waited;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(FUNC_QUERY, 0, 0, 0, 0);
        send_command(FUNC_REMOVE, 127, 15, 0, 0);
        send_command(FUNC_REM_CHN, 0, 15, 0, 0);
        send_command(FUNC_SPARE_A, 5, 5, 5, 1);
        send_command(FUNC_ADD, 127, 15, 0, 0);
        send_command(FUNC_ADD, 0, 0, 0, 0);
        send_command(FUNC_ADD, 127, 3, 0, 0);
        send_command(FUNC_ADD, 64, 8, 0, 0);
        send_command(FUNC_ADD, 64, 9, 0, 0);
        send_command(FUNC_QUERY, 0, 0, 0, 0);
        send_command(FUNC_QUERY, 0, 0, 0, 1);
        send_command(FUNC_QUERY, 0, 0, 4, 1);
        send_command(FUNC_QUERY, 0, 0, 4, 0);
        send_command(FUNC_QUERY, 0, 0, 5, 0);
        send_command(FUNC_QUERY, 127, 15, 15, 1);
        send_command(FUNC_SPARE_B, 127, 15, 15, 1);
        send_command(FUNC_REMOVE, 127, 7, 0, 0);
        send_command(FUNC_REMOVE, 127, 15, 0, 0);
        send_command(FUNC_REM_CHN, 0, 9, 0, 0);
        send_command(FUNC_SPARE_C, 0, 0, 0, 0);
        send_command(FUNC_CLEAR, 0, 0, 0, 0);
        send_command(FUNC_QUERY, 0, 0, 0, 0);
        send_command(FUNC_CLEAR, 0, 0, 0, 0);

        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items % 60 == 59)
            begin
                case ($urandom_range(0, 4))
                    0: fill_goal = 0;
                    1: fill_goal = 1;
                    2, 3: fill_goal = MAX_NOTES;
                    default: fill_goal = $urandom_range(2, MAX_NOTES - 1);
                endcase
            end
            if (done_items % 100 == 99)
                calm = ($urandom_range(0, 3) == 0);
            wind_down = (done_items >= RANDOM_ITEMS - WIND_DOWN_ITEMS);
            pick_command(f, n, pos, top);
            send_command(f, n.tone, n.chan, pos, top);
            if (f <= FUNC_QUERY)
                done_items++;
        end
        in_valid <= 1'b0;

        waited = 0;
        while (tracker.replies_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #(6_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
